### rtl/core/lphi_pkg.sv
// ----------------------------------------------------------------------------
// Linear probe hash insert package
// Shared widths, mixing constants, result codes and controller states for the
// insert-only linear probing hash table.
// ----------------------------------------------------------------------------
package lphi_pkg;

  // Table geometry. The slot count is a power of two, so the modulo of the
  // mixed key is a mask of its low bits.
  localparam int SLOTS    = 1024;
  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int CNT_W    = SLOT_W + 1;

  // Item field widths.
  localparam int KEY_W    = 64;
  localparam int TAG_W    = 16;
  localparam int STATUS_W = 2;
  localparam int HALF_W   = KEY_W / 2;

  // One memory word holds the valid flag, the tag and the key.
  localparam int MEM_W    = 1 + TAG_W + KEY_W;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_DATA_W  = ((KEY_W + TAG_W + 7) / 8) * 8;
  localparam int OUT_RAW_W  = STATUS_W + SLOT_W + CNT_W;
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  // Key mixing constants.
  localparam logic [HALF_W-1:0] MUL_A = 32'd3258939961;
  localparam logic [HALF_W-1:0] MUL_B = 32'd2360029849;
  localparam int SH_A = 7;
  localparam int SH_B = 11;
  localparam int SH_C = 19;

  // Result codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 2'd0,
    ST_PRESENT  = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MA_LO,
    S_MA_HI,
    S_MA_SUM,
    S_MB_LO,
    S_MB_HI,
    S_MB_SUM,
    S_READ,
    S_CHECK,
    S_RESP
  } fsm_t;

endpackage

### rtl/core/linear_probe_hash_insert.sv
// ----------------------------------------------------------------------------
// Linear probe hash insert
// Hashes a 64-bit key with an xor-shift / multiply mixer, then probes a
// 1024-slot table linearly from the home slot and inserts the key and tag in
// the first empty slot, or reports the key as present or the table as full.
//
//   Channel   Direction  Payload (lowest bits first)
//   s_*       in         key[63:0], entry_tag[79:64]
//   m_*       out        status[1:0], slot[11:2], count[22:12], zero pad
//
// The mixer shares one 32x32 multiplier between the halves of the key. Each
// probe is one memory read and one check, and a request at full capacity
// goes straight to the result without mixing or probing. After reset a
// clearing pass writes every slot empty, during which no item is accepted.
// A result waits in the output register while m_tready is low, and one
// request is in work at a time.
// ----------------------------------------------------------------------------
module linear_probe_hash_insert
  import lphi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // key[63:0], entry_tag[79:64]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata    // status[1:0], slot[11:2], count[22:12]
);

  // Control state.
  fsm_t              state;
  fsm_t              state_next;
  logic [CNT_W-1:0]  element_count;
  logic [SLOT_W-1:0] clr_addr;
  logic [CNT_W-1:0]  probe_cnt;
  logic              out_valid;

  // Payload registers.
  logic [KEY_W-1:0]      key_q;
  logic [TAG_W-1:0]      tag_q;
  logic [KEY_W-1:0]      mix_x;
  logic [KEY_W-1:0]      prod_lo;
  logic [HALF_W-1:0]     prod_hi;
  logic [SLOT_W-1:0]     probe_addr;
  status_t               res_status;
  logic [SLOT_W-1:0]     res_slot;
  logic [OUT_DATA_W-1:0] out_data;

  // Memory and its port.
  logic [MEM_W-1:0]  mem [SLOTS];
  logic [MEM_W-1:0]  mem_rdata;
  logic [MEM_W-1:0]  mem_wdata;
  logic [SLOT_W-1:0] mem_addr;
  logic              mem_we;

  // Datapath signals.
  logic              accept;
  logic              out_load;
  logic [HALF_W-1:0] mul_in;
  logic [HALF_W-1:0] mul_const;
  logic [KEY_W-1:0]  mul_out;
  logic [KEY_W-1:0]  prod_sum;
  logic [KEY_W-1:0]  in_key;
  logic [TAG_W-1:0]  in_tag;
  logic              rd_valid;
  logic              key_match;
  logic              last_probe;
  logic              at_capacity;

  assign in_key = s_tdata[KEY_W-1:0];
  assign in_tag = s_tdata[KEY_W+TAG_W-1:KEY_W];
  assign accept = s_tvalid && s_tready;

  assign rd_valid    = mem_rdata[MEM_W-1];
  assign key_match   = (mem_rdata[KEY_W-1:0] == key_q);
  assign last_probe  = (probe_cnt == CNT_W'(SLOTS - 1));
  assign at_capacity = (element_count == CNT_W'(SLOTS));

  // Shared multiplier: one 32-bit half of the mixed key by a 32-bit constant.
  always_comb begin
    mul_in    = mix_x[HALF_W-1:0];
    mul_const = MUL_A;
    case (state)
      S_MA_LO: begin
        mul_in = mix_x[HALF_W-1:0];
        mul_const = MUL_A;
      end
      S_MA_HI: begin
        mul_in = mix_x[KEY_W-1:HALF_W];
        mul_const = MUL_A;
      end
      S_MB_LO: begin
        mul_in = mix_x[HALF_W-1:0];
        mul_const = MUL_B;
      end
      S_MB_HI: begin
        mul_in = mix_x[KEY_W-1:HALF_W];
        mul_const = MUL_B;
      end
      default: begin
        mul_in = mix_x[HALF_W-1:0];
        mul_const = MUL_A;
      end
    endcase
  end

  assign mul_out  = {{HALF_W{1'b0}}, mul_in} * {{HALF_W{1'b0}}, mul_const};
  // The high half product only reaches the upper 32 bits, modulo 2^64.
  assign prod_sum = prod_lo + {prod_hi, {HALF_W{1'b0}}};

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_addr == SLOT_W'(SLOTS - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_tvalid) state_next = at_capacity ? S_RESP : S_MA_LO;
      end
      S_MA_LO:  state_next = S_MA_HI;
      S_MA_HI:  state_next = S_MA_SUM;
      S_MA_SUM: state_next = S_MB_LO;
      S_MB_LO:  state_next = S_MB_HI;
      S_MB_HI:  state_next = S_MB_SUM;
      S_MB_SUM: state_next = S_READ;
      S_READ:   state_next = S_CHECK;
      S_CHECK: begin
        if (!rd_valid || key_match || last_probe) state_next = S_RESP;
        else state_next = S_READ;
      end
      S_RESP: begin
        if (!out_valid || m_tready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs of the controller: handshake, memory port and result load.
  always_comb begin
    s_tready  = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = probe_addr;
    mem_wdata = {1'b1, tag_q, key_q};
    out_load  = 1'b0;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_addr;
        mem_wdata = '0;
      end
      S_IDLE: s_tready = 1'b1;
      S_CHECK: mem_we = !rd_valid;
      S_RESP: out_load = !out_valid || m_tready;
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Table memory: one read or write port, registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    mem_rdata <= mem[mem_addr];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      element_count <= '0;
      clr_addr      <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (state == S_CHECK && !rd_valid) element_count <= element_count + 1'b1;
      if (out_load) out_valid <= 1'b1;
      else if (m_tready) out_valid <= 1'b0;
    end
  end

  // Mixer, probe walk and result registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          key_q      <= in_key;
          tag_q      <= in_tag;
          mix_x      <= in_key ^ (in_key >> SH_A);
          res_status <= ST_FULL;
          res_slot   <= '0;
        end
      end
      S_MA_LO, S_MB_LO: prod_lo <= mul_out;
      S_MA_HI, S_MB_HI: prod_hi <= mul_out[HALF_W-1:0];
      S_MA_SUM: mix_x <= prod_sum ^ (prod_sum >> SH_B);
      S_MB_SUM: begin
        // Home slot is the mixed key modulo the slot count.
        probe_addr <= SLOT_W'(prod_sum ^ (prod_sum >> SH_C));
        probe_cnt  <= '0;
      end
      S_CHECK: begin
        if (!rd_valid) begin
          res_status <= ST_INSERTED;
          res_slot   <= probe_addr;
        end else if (key_match) begin
          res_status <= ST_PRESENT;
          res_slot   <= probe_addr;
        end else if (last_probe) begin
          res_status <= ST_FULL;
          res_slot   <= '0;
        end else begin
          probe_addr <= probe_addr + 1'b1;
          probe_cnt  <= probe_cnt + 1'b1;
        end
      end
      S_RESP: begin
        if (out_load) begin
          out_data <= OUT_DATA_W'({element_count, res_slot, res_status});
        end
      end
      default: begin
        probe_cnt <= probe_cnt;
      end
    endcase
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  // The element count never passes the slot count.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    element_count <= CNT_W'(SLOTS))
    else $error("element count above capacity");

  // Memory writes happen only in the clearing pass or on an insert.
  a_write_state: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_CLEAR || state == S_CHECK))
    else $error("memory write outside clear or insert");

  // An insert raises the count by exactly one.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK && !rd_valid) |=> element_count == $past(element_count) + 1'b1)
    else $error("count not advanced on insert");

  // A full result always reports slot zero.
  a_full_slot: assert property (@(posedge clk) disable iff (rst)
    (out_load && res_status == ST_FULL) |-> res_slot == '0)
    else $error("full result with nonzero slot");

  // No item is taken while a request is in work.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ || state == S_CHECK || state == S_RESP) |-> !s_tready)
    else $error("input ready during request");

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// Linear probe hash insert testbench
// Drives insert requests over the input stream and checks every result on
// the output stream against a behavioral hash table kept in the bench. A
// short directed table covers key extremes, home slot collisions and the
// wrap at the last slot. It is followed by random inserts with many repeated
// keys and a long receiver hold-off, and ends with a stretch without idling.
// ----------------------------------------------------------------------------
module tb_top;
  import lphi_pkg::*;

  // One expected result on the output stream.
  typedef struct {
    status_t             status;
    logic [SLOT_W-1:0]   slot;
    logic [CNT_W-1:0]    count;
  } hash_result_t;

  // One insert request, with optional fixed expectations.
  typedef struct {
    logic [KEY_W-1:0]    key;
    logic [TAG_W-1:0]    tag;
    bit                  fix_status_count;
    status_t             status;
    logic [CNT_W-1:0]    count;
    bit                  fix_slot;
    logic [SLOT_W-1:0]   slot;
  } insert_req_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;    // key[63:0], entry_tag[79:64]
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;         // status[1:0], slot[11:2], count[22:12]

  // Bench copy of the table.
  bit                    occupied [SLOTS];
  logic [KEY_W-1:0]      stored_key [SLOTS];
  int                    stored_count = 0;

  hash_result_t          pending_results [$];
  logic [KEY_W-1:0]      used_keys [$];
  int                    errors = 0;
  bit                    calm = 1'b0;
  bit                    pressure_go = 1'b0;

  linear_probe_hash_insert dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #10 clk = ~clk;

  // Home slot of a key: xor-shift and wrapping multiply mixer, then the low bits.
  function automatic logic [SLOT_W-1:0] home_of(logic [KEY_W-1:0] k);
    logic [KEY_W-1:0] x;
    x = k;
    x = x ^ (x >> SH_A);
    x = x * {{(KEY_W-HALF_W){1'b0}}, MUL_A};
    x = x ^ (x >> SH_B);
    x = x * {{(KEY_W-HALF_W){1'b0}}, MUL_B};
    x = x ^ (x >> SH_C);
    return x[SLOT_W-1:0];
  endfunction

  // Insert a key into the bench table and return the result the block owes.
  function automatic hash_result_t predict_insert(logic [KEY_W-1:0] k);
    hash_result_t r;
    int unsigned  s;
    int           p;
    bit           done;
    r.status = ST_FULL;
    r.slot   = '0;
    done     = 1'b0;
    if (stored_count < SLOTS) begin
      s = home_of(k);
      p = 0;
      while (!done && p < SLOTS) begin
        if (!occupied[s]) begin
          occupied[s]   = 1'b1;
          stored_key[s] = k;
          stored_count++;
          r.status = ST_INSERTED;
          r.slot   = SLOT_W'(s);
          done     = 1'b1;
        end else if (stored_key[s] == k) begin
          r.status = ST_PRESENT;
          r.slot   = SLOT_W'(s);
          done     = 1'b1;
        end else begin
          s = (s + 1) % SLOTS;
          p++;
        end
      end
    end
    r.count = CNT_W'(stored_count);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("tb: mismatch on %s: got %0d, want %0d", what, got, want);
    errors++;
  endtask

  // Offer one request, wait for its transfer, then record its expected result.
  task automatic offer_insert(input insert_req_t req);
    int           gap;
    hash_result_t r;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_DATA_W'({req.tag, req.key});
    do @(posedge clk); while (!s_tready);
    r = predict_insert(req.key);
    if (req.fix_status_count) begin
      r.status = req.status;
      r.count  = req.count;
    end
    if (req.fix_slot) begin
      r.slot = req.slot;
    end
    pending_results.push_back(r);
  endtask

  function automatic insert_req_t plain_req(logic [KEY_W-1:0] k, logic [TAG_W-1:0] t);
    insert_req_t q;
    q.key              = k;
    q.tag              = t;
    q.fix_status_count = 1'b0;
    q.status           = ST_INSERTED;
    q.count            = '0;
    q.fix_slot         = 1'b0;
    q.slot             = '0;
    return q;
  endfunction

  function automatic insert_req_t fixed_req(logic [KEY_W-1:0] k, logic [TAG_W-1:0] t,
                                            status_t st, int cnt);
    insert_req_t q;
    q                  = plain_req(k, t);
    q.fix_status_count = 1'b1;
    q.status           = st;
    q.count            = CNT_W'(cnt);
    if (st == ST_FULL) begin
      q.fix_slot = 1'b1;
      q.slot     = '0;
    end
    return q;
  endfunction

  function automatic logic [KEY_W-1:0] random_key();
    return {$urandom, $urandom};
  endfunction

  // Receiver: random stall bursts, one long hold-off, no stalls at the end.
  initial begin : receiver
    int  stall_left;
    bit  long_done;
    stall_left = 0;
    long_done  = 1'b0;
    forever begin
      @(posedge clk);
      if (!long_done && pressure_go) begin
        long_done  = 1'b1;
        stall_left = 400;
      end else if (stall_left == 0 && !calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 17);
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Each result transfer is matched against the oldest expected result.
  always @(posedge clk) begin : result_check
    hash_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", m_tdata, 0);
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[STATUS_W-1:0] != want.status)
          report_mismatch("status", m_tdata[STATUS_W-1:0], want.status);
        if (m_tdata[STATUS_W +: SLOT_W] != want.slot)
          report_mismatch("slot", m_tdata[STATUS_W +: SLOT_W], want.slot);
        if (m_tdata[STATUS_W+SLOT_W +: CNT_W] != want.count)
          report_mismatch("count", m_tdata[STATUS_W+SLOT_W +: CNT_W], want.count);
      end
    end
  end

  // Stimulus.
  initial begin : sender
    insert_req_t      directed [$];
    logic [KEY_W-1:0] near_zero [$];
    logic [KEY_W-1:0] near_end [$];
    logic [KEY_W-1:0] k;
    logic [KEY_W-1:0] ones;
    int               pick;
    int               n;

    ones = '1;

    // Keys sharing the home slot of key zero, and keys homed on the last slot.
    k = 64'd100;
    while (near_zero.size() < 3 || near_end.size() < 3) begin
      if (near_zero.size() < 3 && home_of(k) == home_of('0)) near_zero.push_back(k);
      else if (near_end.size() < 3 && home_of(k) == SLOT_W'(SLOTS - 1)) near_end.push_back(k);
      k++;
    end

    // Directed table: extremes, repeats, collisions and the wrap past the end.
    directed.push_back(fixed_req('0, '0, ST_INSERTED, 1));
    directed.push_back(fixed_req('0, '1, ST_PRESENT, 1));
    directed.push_back(fixed_req(ones, '1, ST_INSERTED, 2));
    directed.push_back(fixed_req(ones, '0, ST_PRESENT, 2));
    directed.push_back(fixed_req(64'd1, 16'h0001, ST_INSERTED, 3));
    directed.push_back(plain_req(64'h8000_0000_0000_0000, 16'h8000));
    directed.push_back(plain_req(64'h5555_5555_5555_5555, 16'h5555));
    directed.push_back(plain_req(64'hAAAA_AAAA_AAAA_AAAA, 16'hAAAA));
    foreach (near_zero[i]) directed.push_back(plain_req(near_zero[i], 16'(16'h1000 + i)));
    directed.push_back(plain_req(near_zero[0], 16'h2000));
    directed.push_back(plain_req(near_zero[2], 16'h2001));
    foreach (near_end[i]) directed.push_back(plain_req(near_end[i], 16'(16'h3000 + i)));
    directed.push_back(plain_req(near_end[2], 16'h4000));
    directed.push_back(plain_req('0, 16'h7FFF));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      offer_insert(directed[i]);
      used_keys.push_back(directed[i].key);
    end

    // Random inserts: fresh keys, repeats of stored keys, small keys, bit patterns.
    for (n = 0; n < 480; n++) begin
      if (n == 100) pressure_go = 1'b1;
      if (n >= 420) calm = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        k = random_key();
        used_keys.push_back(k);
      end else if (pick < 85) begin
        k = used_keys[$urandom_range(0, used_keys.size() - 1)];
      end else if (pick < 93) begin
        k = KEY_W'($urandom_range(0, 255));
      end else if (pick < 97) begin
        k = ones << $urandom_range(0, 63);
        k = {k[KEY_W-1:1], 1'b1} & ~(64'd1 << $urandom_range(0, 63));
      end else begin
        k = 64'd1 << $urandom_range(0, 63);
      end
      offer_insert(plain_req(k, 16'($urandom)));
    end
    s_tvalid <= 1'b0;

    // Drain, then watch a little longer for stray results.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin : watchdog
    #(64'd420_000_000);
    $display("tb: failure");
    $finish;
  end

endmodule
